/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the bucket hash core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define LBH_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lbh check failed: condition broken");

// Check that a trigger is always accompanied by a condition in the same cycle.
`define LBH_ASSERT_IMPLIES(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("lbh check failed: implication broken");

`endif

/* hdl/lbh_pkg.sv */
// Shared types and constants of the bucket hash core.
package lbh_pkg;

  localparam int MAX_PAIRS   = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_ADDR_W  = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_BITS_IN_USE = 3'd0;
  localparam logic [4:0] BITS_IN_USE_RST = 5'd8;

  typedef struct packed {
    logic [15:0] dist_a;
    logic [15:0] dist_b;
    logic [15:0] dist_pair;
  } in_item_t;

  typedef struct packed {
    logic [15:0] bucket;
    logic        zero_divisor;
  } out_item_t;

  // One classified pair waiting for the divider.
  typedef struct packed {
    logic [32:0] mag;
    logic [16:0] divisor;
    logic        zero;
  } proj_job_t;

  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SCAN,
    BK_MED,
    BK_HASH
  } back_state_t;

endpackage

/* hdl/lbh_front.sv */
// Front end: accept pairs, square the distances and classify each pair.
module lbh_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lbh_pkg::in_item_t    in_data,
  output logic                 push,
  output lbh_pkg::proj_job_t   job,
  input  logic                 full
);

  logic        v1_r, v1_nxt;
  logic [31:0] asq_r, bsq_r, csq_r;
  logic [15:0] c_r;
  logic        accept;
  logic [32:0] pos, neg;

  assign in_ready = !v1_r || !full;
  assign accept   = in_valid && in_ready;
  assign push     = v1_r && !full;

  always_comb begin
    v1_nxt = v1_r;
    if (accept) begin
      v1_nxt = 1'b1;
    end else if (push) begin
      v1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      asq_r <= 32'(in_data.dist_a) * 32'(in_data.dist_a);
      bsq_r <= 32'(in_data.dist_b) * 32'(in_data.dist_b);
      csq_r <= 32'(in_data.dist_pair) * 32'(in_data.dist_pair);
      c_r   <= in_data.dist_pair;
    end
  end

  // Magnitude of a^2 + b^2 - c^2, divisor 2c.
  always_comb begin
    pos         = {1'b0, asq_r} + {1'b0, bsq_r};
    neg         = {1'b0, csq_r};
    job.mag     = (pos >= neg) ? (pos - neg) : (neg - pos);
    job.divisor = {c_r, 1'b0};
    job.zero    = (c_r == 16'd0);
  end

endmodule

/* hdl/lbh_fifo.sv */
// Short queue of classified pairs between front and back end.
module lbh_fifo #(
  parameter int DEPTH = lbh_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lbh_pkg::proj_job_t wr_data,
  output logic               full,
  input  logic               pop,
  output logic               rd_valid,
  output lbh_pkg::proj_job_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lbh_pkg::proj_job_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

/* hdl/lbh_div.sv */
// Radix-2 restoring divider, 33-bit dividend by 17-bit divisor, one bit a cycle.
module lbh_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lbh_pkg::div_req_t req,
  output lbh_pkg::div_rsp_t rsp
);

  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [32:0] dq_r, dq_nxt;
  logic [16:0] rem_r, rem_nxt, dvs_r;
  logic [17:0] trial;

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = dq_r[31:0];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dq_r[32]};
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dq_nxt   = req.dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 17'(trial - {1'b0, dvs_r});
        dq_nxt  = {dq_r[31:0], 1'b1};
      end else begin
        rem_nxt = trial[16:0];
        dq_nxt  = {dq_r[31:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == 6'd32) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

endmodule

/* hdl/lbh_back.sv */
// Back end: run the divider, collect projections, find the median, build the bucket.
module lbh_back #(
  parameter int MAX_PAIRS = lbh_pkg::MAX_PAIRS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clear,
  input  logic [$clog2(MAX_PAIRS+1)-1:0]  k,
  input  logic                            job_valid,
  input  lbh_pkg::proj_job_t              job,
  output logic                            job_pop,
  output lbh_pkg::div_req_t               div_req,
  input  lbh_pkg::div_rsp_t               div_rsp,
  input  logic                            out_free,
  output logic                            out_load,
  output lbh_pkg::out_item_t              out_item
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  lbh_pkg::back_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             err_r, err_nxt;
  logic [31:0]      proj_r [MAX_PAIRS];
  logic [31:0]      lo_r, lo_nxt, hi_r, hi_nxt, med_r, med_nxt;
  logic             wr_en;
  logic [31:0]      wr_val;
  logic             store;
  logic [31:0]      cand;
  logic [CNT_W-1:0] lt_cnt, le_cnt, r_hi, r_lo;
  logic [32:0]      mid_sum;
  logic [31:0]      bucket_full;
  logic [4:0]       pos;

  assign r_hi = k >> 1;
  assign r_lo = r_hi - 1'b1;
  assign cand = proj_r[j_r];

  // Rank of the candidate among the live projections.
  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int i = 0; i < MAX_PAIRS; i++) begin
      if (CNT_W'(i) < k) begin
        if (proj_r[i] < cand) begin
          lt_cnt = lt_cnt + 1'b1;
        end
        if (proj_r[i] <= cand) begin
          le_cnt = le_cnt + 1'b1;
        end
      end
    end
  end

  always_comb begin
    bucket_full = '0;
    pos         = '0;
    for (int i = 0; i < MAX_PAIRS; i++) begin
      pos = 5'(k - CNT_W'(1) - CNT_W'(i));
      if (CNT_W'(i) < k && proj_r[i] >= med_r) begin
        bucket_full[pos] = 1'b1;
      end
    end
  end

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    j_nxt            = j_r;
    err_nxt          = err_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    med_nxt          = med_r;
    wr_en            = 1'b0;
    wr_val           = div_rsp.quot;
    store            = 1'b0;
    job_pop          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = job.mag;
    div_req.divisor  = job.divisor;
    out_load         = 1'b0;
    out_item.bucket       = bucket_full[15:0];
    out_item.zero_divisor = err_r;
    case (state_r)
      lbh_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          if (job.zero) begin
            wr_val  = '0;
            err_nxt = 1'b1;
            store   = 1'b1;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = lbh_pkg::BK_DIV;
          end
        end
      end
      lbh_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          store = 1'b1;
        end
      end
      lbh_pkg::BK_SCAN: begin
        if (lt_cnt <= r_hi && r_hi < le_cnt) begin
          hi_nxt = cand;
        end
        if (lt_cnt <= r_lo && r_lo < le_cnt) begin
          lo_nxt = cand;
        end
        j_nxt = j_r + 1'b1;
        if (CNT_W'(j_r) + CNT_W'(1) == k) begin
          state_nxt = lbh_pkg::BK_MED;
        end
      end
      lbh_pkg::BK_MED: begin
        med_nxt   = k[0] ? hi_r : mid_sum[32:1];
        state_nxt = lbh_pkg::BK_HASH;
      end
      lbh_pkg::BK_HASH: begin
        if (out_free) begin
          out_load  = 1'b1;
          cnt_nxt   = '0;
          err_nxt   = 1'b0;
          state_nxt = lbh_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = lbh_pkg::BK_IDLE;
      end
    endcase

    // Store one projection; close the set once k are in.
    if (store) begin
      wr_en = 1'b1;
      if (cnt_r + 1'b1 == k) begin
        j_nxt     = '0;
        state_nxt = lbh_pkg::BK_SCAN;
      end else begin
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = lbh_pkg::BK_IDLE;
      end
    end

    if (clear) begin
      cnt_nxt = '0;
      err_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbh_pkg::BK_IDLE;
      cnt_r   <= '0;
      err_r   <= 1'b0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    med_r <= med_nxt;
    if (wr_en) begin
      proj_r[cnt_r[IDX_W-1:0]] <= wr_val;
    end
  end

endmodule

/* hdl/metric_lsh_bucket_hash_core.sv */
// Top level of the pivot-pair projection bucket hash core.
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one pivot pair per transfer:
//   the object's distances to both pivots and the distance between the pivots.
//   After k pairs (bits_in_use, 0 read as 1, capped at 16), one bucket index
//   leaves (out_valid/out_ready/out_data), flagged on any zero pivot distance.
//   Configuration sits on an APB-style port; bits_in_use is at byte address 0.
//   Writing it abandons any set in progress.
// Flow:
//   The front squares the distances and queues each pair; the back divides
//   with a one-bit-per-cycle divider, so each pair passes through the back
//   as pop, 33 divide steps and store. A pair with a zero pivot distance
//   is stored in the same cycle as its pop. Closing a set adds one median
//   rank scan per stored projection, then a median step and the result load.
// Reset:
//   Clears the queue, counters and error flag; bits_in_use returns to 8.
// Stall:
//   The result register holds a finished bucket until out_ready; the back
//   then waits before loading the next one, the queue fills, and in_ready drops.
module metric_lsh_bucket_hash_core #(
  parameter int MAX_PAIRS   = lbh_pkg::MAX_PAIRS,
  parameter int QUEUE_DEPTH = lbh_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lbh_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lbh_pkg::out_item_t                out_data,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lbh_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);

  // Configuration register.
  logic [4:0]       biu_r, biu_nxt;
  logic             cfg_wr;
  logic [5:0]       k_sat;
  logic [CNT_W-1:0] k;

  // Front to queue, queue to back.
  logic               push, full, job_valid, job_pop;
  lbh_pkg::proj_job_t front_job, job;
  lbh_pkg::div_req_t  div_req;
  lbh_pkg::div_rsp_t  div_rsp;

  // Result register.
  logic               out_valid_r, out_valid_nxt, out_load, out_free;
  lbh_pkg::out_item_t out_data_r, out_item;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr == lbh_pkg::ADDR_BITS_IN_USE);
  assign cfg_prdata = (cfg_paddr == lbh_pkg::ADDR_BITS_IN_USE) ? {27'd0, biu_r} : 32'd0;
  assign biu_nxt    = cfg_wr ? cfg_pwdata[4:0] : biu_r;

  // Zero counts as one pair; saturate at the store depth.
  always_comb begin
    k_sat = {1'b0, biu_r};
    if (k_sat == 6'd0) begin
      k_sat = 6'd1;
    end else if (k_sat > 6'(MAX_PAIRS)) begin
      k_sat = 6'(MAX_PAIRS);
    end
    k = CNT_W'(k_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r <= lbh_pkg::BITS_IN_USE_RST;
    end else begin
      biu_r <= biu_nxt;
    end
  end

  lbh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .job      (front_job),
    .full     (full)
  );

  lbh_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (front_job),
    .full     (full),
    .pop      (job_pop),
    .rd_valid (job_valid),
    .rd_data  (job)
  );

  lbh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lbh_back #(.MAX_PAIRS(MAX_PAIRS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_wr),
    .k         (k),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_free  (out_free),
    .out_load  (out_load),
    .out_item  (out_item)
  );

  // Hold the result until the receiver takes the transfer.
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_item;
    end
  end

  `include "assert_macros.svh"

  `LBH_ASSERT_IMPLIES(a_no_overflow, push, !full || job_pop)
  `LBH_ASSERT_IMPLIES(a_pop_has_data, job_pop, job_valid)
  `LBH_ASSERT_IMPLIES(a_div_start_idle, div_req.start, !div_rsp.busy)
  `LBH_ASSERT_IMPLIES(a_load_free, out_load, !out_valid_r || out_ready)

endmodule

/* test/tb_metric_lsh_bucket_hash_core.sv */
// Testbench of the pivot-pair projection bucket hash core.
module tb_metric_lsh_bucket_hash_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lbh_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Predictor state: a shadow of the block's register and set in progress.
  logic [4:0] shadow_bits;
  logic [31:0] shadow_proj [MAX_PAIRS];
  int unsigned shadow_count;
  logic shadow_err;
  out_item_t bucket_q [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold = 0;
  bit rx_stall_long = 1'b0;

  metric_lsh_bucket_hash_core dut (.*);

  always #10 clk = ~clk;

  // Abort the run on a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  function automatic int unsigned set_size();
    int unsigned k;
    k = shadow_bits;
    if (k == 0) k = 1;
    if (k > MAX_PAIRS) k = MAX_PAIRS;
    return k;
  endfunction

  // Fold one pair into the shadow set; queue a bucket when the set closes.
  task automatic predict_bucket(input in_item_t it);
    logic [33:0] pos, neg, mag;
    logic [31:0] p, v;
    logic [31:0] srt [MAX_PAIRS];
    logic [32:0] med;
    logic [15:0] bkt;
    int unsigned k, j;
    out_item_t res;
    k = set_size();
    if (it.dist_pair == 0) begin
      p = '0;
      shadow_err = 1'b1;
    end else begin
      pos = 34'(it.dist_a) * it.dist_a + 34'(it.dist_b) * it.dist_b;
      neg = 34'(it.dist_pair) * it.dist_pair;
      mag = (pos >= neg) ? pos - neg : neg - pos;
      p = 32'(mag / (34'(it.dist_pair) * 2));
    end
    if (shadow_count >= k) shadow_count = 0;
    shadow_proj[shadow_count] = p;
    shadow_count++;
    if (shadow_count < k) return;
    for (int i = 0; i < k; i++) begin
      v = shadow_proj[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    if (k % 2 == 0) med = (33'(srt[k/2]) + srt[k/2-1]) >> 1;
    else med = srt[k/2];
    bkt = '0;
    for (int i = 0; i < k; i++)
      if (33'(shadow_proj[i]) >= med) bkt[k-1-i] = 1'b1;
    res.bucket = bkt;
    res.zero_divisor = shadow_err;
    bucket_q.push_back(res);
    shadow_count = 0;
    shadow_err = 1'b0;
  endtask

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Send one pair as a single transfer, with a random gap in front.
  // Valid stays high after the transfer; a gap or an idle phase drops it.
  task automatic send_pair(input in_item_t it);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_bucket(it);
  endtask

  // Wait for every queued bucket, then let the back finish pending divides.
  task automatic settle();
    in_valid <= 1'b0;
    while (bucket_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; abandon the set in the shadow too.
  task automatic write_bits(input logic [31:0] val);
    settle();
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_BITS_IN_USE; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    shadow_bits = val[4:0];
    shadow_count = 0;
    shadow_err = 1'b0;
  endtask

  function automatic in_item_t rand_pair();
    in_item_t it;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    it.dist_a = 16'($urandom);
    it.dist_b = 16'($urandom);
    it.dist_pair = 16'($urandom);
    if (sel == 0) it.dist_pair = '0;
    else if (sel == 1) it.dist_pair = 16'hFFFF;
    else if (sel < 4) begin
      // Small distances give ties around the median.
      it.dist_a = 16'($urandom_range(0, 7));
      it.dist_b = 16'($urandom_range(0, 7));
      it.dist_pair = 16'($urandom_range(1, 7));
    end
    return it;
  endfunction

  // Result side: random back-pressure, compare each transfer with the oldest bucket.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (bucket_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data), 0);
      end else begin
        if (out_data.bucket !== bucket_q[0].bucket)
          report_mismatch("bucket", 32'(out_data.bucket), 32'(bucket_q[0].bucket));
        if (out_data.zero_divisor !== bucket_q[0].zero_divisor)
          report_mismatch("zero_divisor", 32'(out_data.zero_divisor),
                          32'(bucket_q[0].zero_divisor));
        void'(bucket_q.pop_front());
      end
    end
    if (rx_stall_long) begin
      out_ready <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 29) == 0) begin
      // Occasional long stall of the receiver.
      rx_hold <= $urandom_range(20, 60);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic test_reset_default();
    in_item_t it;
    // Default of eight pairs: extremes of every field.
    it = '{16'hFFFF, 16'hFFFF, 16'h0001}; send_pair(it);
    it = '{16'h0000, 16'h0000, 16'hFFFF}; send_pair(it);
    it = '{16'hFFFF, 16'h0000, 16'hFFFF}; send_pair(it);
    it = '{16'h0000, 16'hFFFF, 16'h0001}; send_pair(it);
    it = '{16'h0003, 16'h0004, 16'h0005}; send_pair(it);
    it = '{16'h0001, 16'h0001, 16'h0002}; send_pair(it);
    it = '{16'h00FF, 16'h0000, 16'h0000}; send_pair(it);
    it = '{16'hAAAA, 16'h5555, 16'h8000}; send_pair(it);
  endtask

  task automatic test_special_sizes();
    in_item_t it;
    // Zero is treated as one pair.
    write_bits(32'd0);
    it = '{16'h0005, 16'h0005, 16'h0000}; send_pair(it);
    it = '{16'h0005, 16'h0005, 16'h0003}; send_pair(it);
    // Above the maximum saturates to sixteen; all ties across an even count.
    write_bits(32'd31);
    for (int i = 0; i < 16; i++) begin
      it = '{16'h0002, 16'h0002, 16'h0002}; send_pair(it);
    end
    // Abandon a partial set by writing the register mid-set.
    write_bits(32'd4);
    it = '{16'h0100, 16'h0000, 16'h0000}; send_pair(it);
    write_bits(32'd2);
    it = '{16'h0009, 16'h0001, 16'h0004}; send_pair(it);
    it = '{16'h0001, 16'h0009, 16'h0004}; send_pair(it);
  endtask

  task automatic test_random_sets();
    int unsigned k_pick [6] = '{1, 16, 3, 8, 5, 2};
    for (int ph = 0; ph < 6; ph++) begin
      write_bits(32'(k_pick[ph]) | ($urandom & 32'hFFFF_FFE0));
      for (int n = 0; n < 120; n++) send_pair(rand_pair());
      if (ph == 2) begin
        // Hold the sender until all buckets have come out.
        in_valid <= 1'b0;
        while (bucket_q.size() != 0) @(posedge clk);
        for (int n = 0; n < 20; n++) send_pair(rand_pair());
      end
    end
    write_bits(32'd17);
    for (int n = 0; n < 40; n++) send_pair(rand_pair());
  endtask

  initial begin
    shadow_bits = BITS_IN_USE_RST;
    shadow_count = 0;
    shadow_err = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_default();
    test_special_sizes();
    test_random_sets();
    // Drain with the receiver always ready.
    rx_stall_long = 1'b1;
    in_valid <= 1'b0;
    while (bucket_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && bucket_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hdl
hdl/lbh_pkg.sv
hdl/lbh_front.sv
hdl/lbh_fifo.sv
hdl/lbh_div.sv
hdl/lbh_back.sv
hdl/metric_lsh_bucket_hash_core.sv
test/tb_metric_lsh_bucket_hash_core.sv
